@@ hw/rtl/tapk_pkg.sv @@
package tapk_pkg;

  localparam int unsigned COORD_WIDTH = 32;
  localparam int unsigned ANCHORS     = 3;

  localparam int unsigned LEN_W   = COORD_WIDTH - 1;
  localparam int unsigned DELTA_W = COORD_WIDTH + 1;
  localparam int unsigned DIFF_W  = COORD_WIDTH + 2;
  localparam int unsigned LSQ_W   = 2 * COORD_WIDTH - 2;
  localparam int unsigned KSQ_W   = 2 * COORD_WIDTH;
  localparam int unsigned CF_W    = 2 * COORD_WIDTH + 1;
  localparam int unsigned PP_W    = COORD_WIDTH + 1 + DIFF_W;
  localparam int unsigned NUM_W   = CF_W + DIFF_W + 1;
  localparam int unsigned DET_W   = 2 * DIFF_W + 1;
  localparam int unsigned DMAG_W  = DET_W - 1;
  localparam int unsigned SQ_W    = 2 * COORD_WIDTH + 2;
  localparam int unsigned SREM_W  = 2 * COORD_WIDTH;
  localparam int unsigned BIT_W   = $clog2(COORD_WIDTH);

  localparam int unsigned IN_DATA_W  = ((3 * LEN_W + 2 * COORD_WIDTH + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = ((2 * COORD_WIDTH + 3 * LEN_W + 7) / 8) * 8;
  localparam int unsigned CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_A1X,
    CFG_A1Y,
    CFG_A2X,
    CFG_A2Y,
    CFG_A3X,
    CFG_A3Y
  } cfg_idx_e;

  // one item inside the divide / square root iteration
  typedef struct packed {
    logic                                cmd;
    logic                                sing;
    logic                                xneg;
    logic                                yneg;
    logic                                xov;
    logic                                yov;
    logic [NUM_W-1:0]                    xrem;
    logic [NUM_W-1:0]                    yrem;
    logic [COORD_WIDTH-1:0]              xq;
    logic [COORD_WIDTH-1:0]              yq;
    logic [ANCHORS-1:0]                  sov;
    logic [ANCHORS-1:0][SREM_W-1:0]      srem;
    logic [ANCHORS-1:0][COORD_WIDTH-1:0] root;
  } iter_t;

endpackage

@@ hw/rtl/tapk_iter.sv @@
module tapk_iter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic [tapk_pkg::BIT_W-1:0]   bit_i,
  input  logic [tapk_pkg::DMAG_W-1:0]  dmag_i,
  input  logic                         vld_i,
  input  tapk_pkg::iter_t              st_i,
  output logic                         vld_o,
  output tapk_pkg::iter_t              st_o
);

  tapk_pkg::iter_t                      st_d;
  logic [tapk_pkg::NUM_W-1:0]           dsh;
  logic [tapk_pkg::SREM_W-1:0]          trial [tapk_pkg::ANCHORS];
  logic [tapk_pkg::BIT_W:0]             rsh;
  logic [tapk_pkg::BIT_W:0]             osh;

  always_comb begin
    st_d = st_i;
    dsh  = tapk_pkg::NUM_W'(dmag_i) << bit_i;
    rsh  = {1'b0, bit_i} + (tapk_pkg::BIT_W+1)'(1);
    osh  = {bit_i, 1'b0};
    // one quotient bit for each axis
    if (st_i.xrem >= dsh) begin
      st_d.xrem        = st_i.xrem - dsh;
      st_d.xq[bit_i]   = 1'b1;
    end
    if (st_i.yrem >= dsh) begin
      st_d.yrem        = st_i.yrem - dsh;
      st_d.yq[bit_i]   = 1'b1;
    end
    // one root bit for each anchor: try (2r + 2^j) * 2^j
    for (int k = 0; k < tapk_pkg::ANCHORS; k++) begin
      trial[k] = (tapk_pkg::SREM_W'(st_i.root[k]) << rsh)
               + (tapk_pkg::SREM_W'(1) << osh);
      if (st_i.srem[k] >= trial[k]) begin
        st_d.srem[k]        = st_i.srem[k] - trial[k];
        st_d.root[k][bit_i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_o <= st_d;
    end
  end

endmodule

@@ hw/rtl/three_anchor_planar_kinematics.sv @@
// Throughput: one beat per cycle while m_axis is not stalled; the 32 divide / square root bit
// stages are fully pipelined.
// The whole pipeline holds while a result beat waits on m_axis_tready_i.
// Reset (rst_ni low, asynchronous): anchors clear to zero, all stage valid bits clear.
// Anchor terms settle after a config write via difference, product and determinant registers.
module three_anchor_planar_kinematics (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [tapk_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [tapk_pkg::COORD_WIDTH-1:0]     cfg_wdata_i,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // length_one, length_two, length_three, target_x, target_y, zero fill
  input  logic [tapk_pkg::IN_DATA_W-1:0]       s_axis_tdata_i,
  // cmd
  input  logic                                 s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // solved_x, solved_y, reach_one, reach_two, reach_three, zero fill
  output logic [tapk_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o,
  // singular, saturated
  output logic [1:0]                           m_axis_tuser_o
);

  localparam int unsigned W  = tapk_pkg::COORD_WIDTH;
  localparam int unsigned NA = tapk_pkg::ANCHORS;
  localparam int unsigned LW = tapk_pkg::LEN_W;

  // ---------------- configuration ----------------
  logic signed [W-1:0] anc_x_q [NA];
  logic signed [W-1:0] anc_y_q [NA];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NA; k++) begin
        anc_x_q[k] <= '0;
        anc_y_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      case (tapk_pkg::cfg_idx_e'(cfg_idx_i))
        tapk_pkg::CFG_A1X: anc_x_q[0] <= cfg_wdata_i;
        tapk_pkg::CFG_A1Y: anc_y_q[0] <= cfg_wdata_i;
        tapk_pkg::CFG_A2X: anc_x_q[1] <= cfg_wdata_i;
        tapk_pkg::CFG_A2Y: anc_y_q[1] <= cfg_wdata_i;
        tapk_pkg::CFG_A3X: anc_x_q[2] <= cfg_wdata_i;
        tapk_pkg::CFG_A3Y: anc_y_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // anchor-derived terms: doubled differences, squared norms, determinant
  logic signed [tapk_pkg::DIFF_W-1:0] ka_q, kb_q, kd_q, ke_q;
  logic        [tapk_pkg::KSQ_W-1:0]  kn_q [NA];
  logic signed [tapk_pkg::KSQ_W-1:0]  pxx [NA];
  logic signed [tapk_pkg::KSQ_W-1:0]  pyy [NA];
  logic signed [tapk_pkg::DET_W-1:0]  pae_q, pbd_q;
  logic signed [tapk_pkg::DET_W-1:0]  det;
  logic        [tapk_pkg::DMAG_W-1:0] dmag_q;
  logic                               dneg_q, dzero_q;

  always_comb begin
    for (int k = 0; k < NA; k++) begin
      pxx[k] = anc_x_q[k] * anc_x_q[k];
      pyy[k] = anc_y_q[k] * anc_y_q[k];
    end
    det = pae_q - pbd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ka_q    <= '0;
      kb_q    <= '0;
      kd_q    <= '0;
      ke_q    <= '0;
      for (int k = 0; k < NA; k++) kn_q[k] <= '0;
      pae_q   <= '0;
      pbd_q   <= '0;
      dmag_q  <= '0;
      dneg_q  <= 1'b0;
      dzero_q <= 1'b1;
    end else begin
      ka_q <= (tapk_pkg::DIFF_W'(anc_x_q[1]) - tapk_pkg::DIFF_W'(anc_x_q[0])) <<< 1;
      kb_q <= (tapk_pkg::DIFF_W'(anc_y_q[1]) - tapk_pkg::DIFF_W'(anc_y_q[0])) <<< 1;
      kd_q <= (tapk_pkg::DIFF_W'(anc_x_q[2]) - tapk_pkg::DIFF_W'(anc_x_q[0])) <<< 1;
      ke_q <= (tapk_pkg::DIFF_W'(anc_y_q[2]) - tapk_pkg::DIFF_W'(anc_y_q[0])) <<< 1;
      for (int k = 0; k < NA; k++) kn_q[k] <= $unsigned(pxx[k]) + $unsigned(pyy[k]);
      pae_q   <= ka_q * ke_q;
      pbd_q   <= kb_q * kd_q;
      dneg_q  <= det[tapk_pkg::DET_W-1];
      dzero_q <= (det == '0);
      dmag_q  <= det[tapk_pkg::DET_W-1] ? tapk_pkg::DMAG_W'(-det) : tapk_pkg::DMAG_W'(det);
    end
  end

  // ---------------- pipeline control ----------------
  logic en;
  logic o_vld_q;

  assign en              = !o_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // stage A: capture
  logic                a_vld_q, a_cmd_q;
  logic [LW-1:0]       a_len_q [NA];
  logic signed [W-1:0] a_tx_q, a_ty_q;

  // stage B: squares of lengths, deltas to anchors
  logic                                b_vld_q, b_cmd_q;
  logic [tapk_pkg::LSQ_W-1:0]          b_rs_q [NA];
  logic signed [tapk_pkg::DELTA_W-1:0] b_dx_q [NA];
  logic signed [tapk_pkg::DELTA_W-1:0] b_dy_q [NA];
  logic [tapk_pkg::LSQ_W-1:0]          b_rs_d [NA];

  // stage C: right-hand sides, squared distances
  logic                             c_vld_q, c_cmd_q;
  logic signed [tapk_pkg::CF_W-1:0] c_c_q, c_f_q;
  logic [tapk_pkg::SQ_W-1:0]        c_sq_q [NA];
  logic signed [tapk_pkg::CF_W-1:0] rs0, rs1, rs2, kn0, kn1, kn2;
  logic signed [tapk_pkg::SQ_W-1:0] pdx [NA];
  logic signed [tapk_pkg::SQ_W-1:0] pdy [NA];

  // stage D: partial products of the numerators
  logic                             d_vld_q, d_cmd_q;
  logic signed [tapk_pkg::PP_W-1:0] d_ce_lo_q, d_ce_hi_q, d_bf_lo_q, d_bf_hi_q;
  logic signed [tapk_pkg::PP_W-1:0] d_af_lo_q, d_af_hi_q, d_cd_lo_q, d_cd_hi_q;
  logic [tapk_pkg::SQ_W-1:0]        d_sq_q [NA];
  logic signed [W:0]                c_lo, c_hi, f_lo, f_hi;

  // stage E: numerators
  logic                              e_vld_q, e_cmd_q;
  logic signed [tapk_pkg::NUM_W-1:0] e_nx_q, e_ny_q;
  logic [tapk_pkg::SQ_W-1:0]         e_sq_q [NA];

  always_comb begin
    for (int k = 0; k < NA; k++) begin
      b_rs_d[k] = tapk_pkg::LSQ_W'(a_len_q[k]) * tapk_pkg::LSQ_W'(a_len_q[k]);
      pdx[k]    = b_dx_q[k] * b_dx_q[k];
      pdy[k]    = b_dy_q[k] * b_dy_q[k];
    end
    rs0  = $signed(tapk_pkg::CF_W'(b_rs_q[0]));
    rs1  = $signed(tapk_pkg::CF_W'(b_rs_q[1]));
    rs2  = $signed(tapk_pkg::CF_W'(b_rs_q[2]));
    kn0  = $signed(tapk_pkg::CF_W'(kn_q[0]));
    kn1  = $signed(tapk_pkg::CF_W'(kn_q[1]));
    kn2  = $signed(tapk_pkg::CF_W'(kn_q[2]));
    c_lo = $signed({1'b0, c_c_q[W-1:0]});
    c_hi = $signed(c_c_q[tapk_pkg::CF_W-1:W]);
    f_lo = $signed({1'b0, c_f_q[W-1:0]});
    f_hi = $signed(c_f_q[tapk_pkg::CF_W-1:W]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= s_axis_tvalid_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
      e_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_cmd_q    <= s_axis_tuser_i;
      a_len_q[0] <= s_axis_tdata_i[LW-1:0];
      a_len_q[1] <= s_axis_tdata_i[2*LW-1:LW];
      a_len_q[2] <= s_axis_tdata_i[3*LW-1:2*LW];
      a_tx_q     <= s_axis_tdata_i[3*LW+W-1:3*LW];
      a_ty_q     <= s_axis_tdata_i[3*LW+2*W-1:3*LW+W];

      b_cmd_q <= a_cmd_q;
      for (int k = 0; k < NA; k++) begin
        b_rs_q[k] <= b_rs_d[k];
        b_dx_q[k] <= tapk_pkg::DELTA_W'(a_tx_q) - tapk_pkg::DELTA_W'(anc_x_q[k]);
        b_dy_q[k] <= tapk_pkg::DELTA_W'(a_ty_q) - tapk_pkg::DELTA_W'(anc_y_q[k]);
      end

      c_cmd_q <= b_cmd_q;
      c_c_q   <= rs0 - rs1 + kn1 - kn0;
      c_f_q   <= rs0 - rs2 + kn2 - kn0;
      for (int k = 0; k < NA; k++) c_sq_q[k] <= $unsigned(pdx[k]) + $unsigned(pdy[k]);

      d_cmd_q   <= c_cmd_q;
      d_ce_lo_q <= c_lo * ke_q;
      d_ce_hi_q <= c_hi * ke_q;
      d_bf_lo_q <= f_lo * kb_q;
      d_bf_hi_q <= f_hi * kb_q;
      d_af_lo_q <= f_lo * ka_q;
      d_af_hi_q <= f_hi * ka_q;
      d_cd_lo_q <= c_lo * kd_q;
      d_cd_hi_q <= c_hi * kd_q;
      for (int k = 0; k < NA; k++) d_sq_q[k] <= c_sq_q[k];

      e_cmd_q <= d_cmd_q;
      e_nx_q  <= (tapk_pkg::NUM_W'(d_ce_hi_q) <<< W) + tapk_pkg::NUM_W'(d_ce_lo_q)
               - (tapk_pkg::NUM_W'(d_bf_hi_q) <<< W) - tapk_pkg::NUM_W'(d_bf_lo_q);
      e_ny_q  <= (tapk_pkg::NUM_W'(d_af_hi_q) <<< W) + tapk_pkg::NUM_W'(d_af_lo_q)
               - (tapk_pkg::NUM_W'(d_cd_hi_q) <<< W) - tapk_pkg::NUM_W'(d_cd_lo_q);
      for (int k = 0; k < NA; k++) e_sq_q[k] <= d_sq_q[k];
    end
  end

  // stage F: magnitudes, signs, overflow checks, iteration seed
  tapk_pkg::iter_t           f_st_d, f_st_q;
  logic                      f_vld_q;
  logic [tapk_pkg::NUM_W-1:0] xabs, yabs, dlim;

  always_comb begin
    xabs = e_nx_q[tapk_pkg::NUM_W-1] ? $unsigned(-e_nx_q) : $unsigned(e_nx_q);
    yabs = e_ny_q[tapk_pkg::NUM_W-1] ? $unsigned(-e_ny_q) : $unsigned(e_ny_q);
    dlim = tapk_pkg::NUM_W'(dmag_q) << W;
    f_st_d      = '0;
    f_st_d.cmd  = e_cmd_q;
    f_st_d.sing = dzero_q;
    f_st_d.xneg = e_nx_q[tapk_pkg::NUM_W-1] ^ dneg_q;
    f_st_d.yneg = e_ny_q[tapk_pkg::NUM_W-1] ^ dneg_q;
    f_st_d.xov  = (xabs >= dlim);
    f_st_d.yov  = (yabs >= dlim);
    f_st_d.xrem = xabs;
    f_st_d.yrem = yabs;
    for (int k = 0; k < NA; k++) begin
      f_st_d.sov[k]  = (e_sq_q[k][tapk_pkg::SQ_W-1:tapk_pkg::LSQ_W] != '0);
      f_st_d.srem[k] = tapk_pkg::SREM_W'(e_sq_q[k][tapk_pkg::LSQ_W-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else if (en) begin
      f_vld_q <= e_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_st_q <= f_st_d;
    end
  end

  // ---------------- bit iteration, MSB first ----------------
  tapk_pkg::iter_t it_st  [W+1];
  logic            it_vld [W+1];

  assign it_st[0]  = f_st_q;
  assign it_vld[0] = f_vld_q;

  for (genvar i = 0; i < W; i++) begin : g_iter
    tapk_iter u_iter (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .bit_i  (tapk_pkg::BIT_W'(W - 1 - i)),
      .dmag_i (dmag_q),
      .vld_i  (it_vld[i]),
      .st_i   (it_st[i]),
      .vld_o  (it_vld[i+1]),
      .st_o   (it_st[i+1])
    );
  end

  // ---------------- output stage: sign, saturation ----------------
  tapk_pkg::iter_t     fin;
  logic                o_cmd_q;
  logic [W-1:0]        sx_d, sy_d;
  logic [LW-1:0]       rc_d [NA];
  logic                sat_d, sing_d;
  logic [W-1:0]        sx_q, sy_q;
  logic [LW-1:0]       rc_q [NA];
  logic                sat_q, sing_q;
  logic [W-1:0]        half, pmax;

  assign fin  = it_st[W];
  assign half = {1'b1, {(W-1){1'b0}}};
  assign pmax = {1'b0, {(W-1){1'b1}}};

  always_comb begin
    sx_d   = '0;
    sy_d   = '0;
    sat_d  = 1'b0;
    sing_d = 1'b0;
    for (int k = 0; k < NA; k++) rc_d[k] = '0;
    if (!fin.cmd) begin
      sing_d = fin.sing;
      if (!fin.sing) begin
        if (fin.xneg) begin
          if (fin.xov || (fin.xq > half)) begin
            sx_d  = half;
            sat_d = 1'b1;
          end else begin
            sx_d = '0 - fin.xq;
          end
        end else if (fin.xov || fin.xq[W-1]) begin
          sx_d  = pmax;
          sat_d = 1'b1;
        end else begin
          sx_d = fin.xq;
        end
        if (fin.yneg) begin
          if (fin.yov || (fin.yq > half)) begin
            sy_d  = half;
            sat_d = 1'b1;
          end else begin
            sy_d = '0 - fin.yq;
          end
        end else if (fin.yov || fin.yq[W-1]) begin
          sy_d  = pmax;
          sat_d = 1'b1;
        end else begin
          sy_d = fin.yq;
        end
      end
    end else begin
      for (int k = 0; k < NA; k++) begin
        if (fin.sov[k]) begin
          rc_d[k] = '1;
          sat_d   = 1'b1;
        end else begin
          rc_d[k] = fin.root[k][LW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
    end else if (en) begin
      o_vld_q <= it_vld[W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      o_cmd_q <= fin.cmd;
      sx_q    <= sx_d;
      sy_q    <= sy_d;
      sat_q   <= sat_d;
      sing_q  <= sing_d;
      for (int k = 0; k < NA; k++) rc_q[k] <= rc_d[k];
    end
  end

  assign m_axis_tvalid_o = o_vld_q;
  assign m_axis_tdata_o  = tapk_pkg::OUT_DATA_W'({rc_q[2], rc_q[1], rc_q[0], sy_q, sx_q});
  assign m_axis_tuser_o  = {sat_q, sing_q};

  // ---------------- assertions ----------------
  a_ready_follows_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("input ready does not follow output stall");

  a_singular_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_vld_q && sing_q) |-> (sx_q == '0 && sy_q == '0 && !sat_q))
    else $error("singular result carries a position or saturation");

  a_inverse_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_vld_q && o_cmd_q) |-> (!sing_q && sx_q == '0 && sy_q == '0))
    else $error("inverse result carries forward fields");

  a_forward_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_vld_q && !o_cmd_q) |-> (rc_q[0] == '0 && rc_q[1] == '0 && rc_q[2] == '0))
    else $error("forward result carries reach fields");

endmodule

@@ test/three_anchor_planar_kinematics_test.sv @@
module three_anchor_planar_kinematics_test;
  import tapk_pkg::*;

  typedef logic signed [191:0] wide_t;

  typedef struct packed {
    logic [31:0] solved_x;
    logic [31:0] solved_y;
    logic [30:0] reach_one;
    logic [30:0] reach_two;
    logic [30:0] reach_three;
    logic        singular;
    logic        saturated;
  } pose_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [COORD_WIDTH-1:0] cfg_wdata_i = '0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  // length_one, length_two, length_three, target_x, target_y, zero fill
  logic [IN_DATA_W-1:0]   s_axis_tdata_i = '0;
  // cmd
  logic                   s_axis_tuser_i = 1'b0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  // solved_x, solved_y, reach_one, reach_two, reach_three, zero fill
  logic [OUT_DATA_W-1:0]  m_axis_tdata_o;
  // singular, saturated
  logic [1:0]             m_axis_tuser_o;

  three_anchor_planar_kinematics dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #4000000;
    $display("three_anchor_planar_kinematics test failed");
    $finish;
  end

  logic signed [31:0] anchor_x [3];
  logic signed [31:0] anchor_y [3];
  pose_result_t       pending_poses [$];
  int                 mismatches = 0;
  bit                 gaps_on = 1'b1;
  int                 hold_request = 0;

  function automatic logic [31:0] clip_coord(wide_t q, ref logic sat);
    if (q > wide_t'(64'sd2147483647)) begin
      sat = 1'b1;
      return 32'h7fffffff;
    end
    if (q < -wide_t'(64'sd2147483648)) begin
      sat = 1'b1;
      return 32'h80000000;
    end
    return q[31:0];
  endfunction

  function automatic pose_result_t solve_pose(bit cmd, logic [30:0] l1, logic [30:0] l2,
                                              logic [30:0] l3, logic signed [31:0] tx,
                                              logic signed [31:0] ty);
    pose_result_t res;
    wide_t wx [3];
    wide_t wy [3];
    wide_t r1, r2, r3, a, b, d, e, c, f, det, base, dx, dy;
    logic [191:0] sq, tt;
    logic [39:0] root, trial;
    logic sat;
    res = '{default: '0};
    sat = 1'b0;
    for (int k = 0; k < 3; k++) begin
      wx[k] = anchor_x[k];
      wy[k] = anchor_y[k];
    end
    if (!cmd) begin
      r1 = {161'd0, l1};
      r2 = {161'd0, l2};
      r3 = {161'd0, l3};
      a = 2 * (wx[1] - wx[0]);
      b = 2 * (wy[1] - wy[0]);
      d = 2 * (wx[2] - wx[0]);
      e = 2 * (wy[2] - wy[0]);
      base = wx[0] * wx[0] + wy[0] * wy[0];
      c = r1 * r1 - r2 * r2 - base + wx[1] * wx[1] + wy[1] * wy[1];
      f = r1 * r1 - r3 * r3 - base + wx[2] * wx[2] + wy[2] * wy[2];
      det = a * e - b * d;
      if (det == 0) begin
        res.singular = 1'b1;
      end else begin
        res.solved_x = clip_coord((c * e - b * f) / det, sat);
        res.solved_y = clip_coord((a * f - c * d) / det, sat);
      end
    end else begin
      for (int k = 0; k < 3; k++) begin
        dx = wide_t'(tx) - wx[k];
        dy = wide_t'(ty) - wy[k];
        sq = dx * dx + dy * dy;
        root = '0;
        for (int i = 39; i >= 0; i--) begin
          trial = root | (40'd1 << i);
          tt = {152'd0, trial};
          if (tt * tt <= sq) root = trial;
        end
        if (root > 40'h7fffffff) begin
          sat = 1'b1;
          root = 40'h7fffffff;
        end
        case (k)
          0: res.reach_one = root[30:0];
          1: res.reach_two = root[30:0];
          default: res.reach_three = root[30:0];
        endcase
      end
    end
    res.saturated = sat;
    return res;
  endfunction

  // result side: random stalls, a long hold on request
  int rx_wait = 0;
  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_request <= hold_request - 1;
      m_axis_tready_i <= 1'b0;
    end else if (m_axis_tvalid_o && m_axis_tready_i) begin
      rx_wait = gaps_on ? $urandom_range(0, 7) : 0;
      m_axis_tready_i <= (rx_wait == 0);
    end else if (rx_wait != 0) begin
      rx_wait = rx_wait - 1;
      m_axis_tready_i <= (rx_wait == 0);
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    pose_result_t want;
    pose_result_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.solved_x    = m_axis_tdata_o[31:0];
      got.solved_y    = m_axis_tdata_o[63:32];
      got.reach_one   = m_axis_tdata_o[94:64];
      got.reach_two   = m_axis_tdata_o[125:95];
      got.reach_three = m_axis_tdata_o[156:126];
      got.singular    = m_axis_tuser_o[0];
      got.saturated   = m_axis_tuser_o[1];
      if (pending_poses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
      end else begin
        want = pending_poses.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  task automatic send_pose(bit cmd, logic [30:0] l1, logic [30:0] l2, logic [30:0] l3,
                           logic signed [31:0] tx, logic signed [31:0] ty);
    int gap;
    gap = gaps_on ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= cmd;
    s_axis_tdata_i <= {3'd0, ty, tx, l3, l2, l1};
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_poses.push_back(solve_pose(cmd, l1, l2, l3, tx, ty));
  endtask

  task automatic drain;
    s_axis_tvalid_i <= 1'b0;
    wait (pending_poses.size() == 0);
    repeat (50) @(posedge clk_i);
  endtask

  // block must be idle; waits for the anchor terms to settle after the writes
  task automatic load_anchors(logic signed [31:0] x1, logic signed [31:0] y1,
                              logic signed [31:0] x2, logic signed [31:0] y2,
                              logic signed [31:0] x3, logic signed [31:0] y3);
    logic [31:0] vals [6];
    cfg_idx_e idx;
    vals = '{x1, y1, x2, y2, x3, y3};
    idx = CFG_A1X;
    for (int i = 0; i < 6; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx;
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
      if (i % 2 == 0) anchor_x[i / 2] = vals[i];
      else anchor_y[i / 2] = vals[i];
      idx = idx.next();
    end
    cfg_we_i <= 1'b0;
    repeat (4) @(posedge clk_i);
  endtask

  task automatic random_target(output logic signed [31:0] tx, output logic signed [31:0] ty);
    if ($urandom_range(0, 3) == 0) begin
      tx = $urandom;
      ty = $urandom;
    end else begin
      tx = $signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000;
      ty = $signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000;
    end
  endtask

  // inverse beat, forward beat from true distances of a random point, or noise
  task automatic random_pose;
    logic signed [31:0] tx, ty;
    pose_result_t span;
    random_target(tx, ty);
    if ($urandom_range(0, 1) == 0) begin
      send_pose(1'b1, 31'($urandom), 31'($urandom), 31'($urandom), tx, ty);
    end else if ($urandom_range(0, 4) != 0) begin
      span = solve_pose(1'b1, '0, '0, '0, tx, ty);
      send_pose(1'b0, span.reach_one, span.reach_two, span.reach_three, $urandom, $urandom);
    end else begin
      send_pose(1'b0, 31'($urandom), 31'($urandom), 31'($urandom), $urandom, $urandom);
    end
  endtask

  task automatic test_reset_anchors;
    send_pose(1'b0, 31'd65536, 31'd131072, 31'd196608, 32'd0, 32'd0);
    send_pose(1'b1, 31'd0, 31'd0, 31'd0, 32'sh00030000, -32'sh00040000);
    drain();
  endtask

  task automatic test_directed;
    pose_result_t span;
    load_anchors(32'sh0, 32'sh0, 32'sh000a0000, 32'sh0, 32'sh0, 32'sh000a0000);
    span = solve_pose(1'b1, '0, '0, '0, 32'sh00030000, 32'sh00040000);
    send_pose(1'b0, span.reach_one, span.reach_two, span.reach_three, '0, '0);
    send_pose(1'b0, '0, '0, '0, '1, '1);
    send_pose(1'b0, '1, '1, '1, '0, '0);
    send_pose(1'b0, '1, '0, '0, '0, '0);
    send_pose(1'b0, '0, '1, '0, '0, '0);
    send_pose(1'b0, '0, '0, '1, '0, '0);
    send_pose(1'b1, '0, '0, '0, 32'sh7fffffff, 32'sh7fffffff);
    send_pose(1'b1, '1, '1, '1, 32'sh80000000, 32'sh80000000);
    send_pose(1'b1, '0, '0, '0, 32'sh80000000, 32'sh7fffffff);
    send_pose(1'b1, '0, '0, '0, 32'sh0, 32'sh0);
    drain();
    // extreme anchors: huge determinant terms and reaches that clip
    load_anchors(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                 32'sh80000000, 32'sh7fffffff);
    send_pose(1'b0, '1, '0, '1, '0, '0);
    send_pose(1'b0, '0, '1, '1, '0, '0);
    send_pose(1'b1, '0, '0, '0, 32'sh7fffffff, 32'sh7fffffff);
    send_pose(1'b1, '0, '0, '0, 32'sh80000000, 32'sh80000000);
    drain();
    // collinear anchors give a zero determinant
    load_anchors(32'sh00010000, 32'sh00010000, 32'sh00020000, 32'sh00020000,
                 32'sh00050000, 32'sh00050000);
    send_pose(1'b0, 31'd100000, 31'd200000, 31'd300000, '0, '0);
    send_pose(1'b1, '0, '0, '0, 32'sh00020000, -32'sh00010000);
    drain();
  endtask

  task automatic test_random_phases;
    logic signed [31:0] c [6];
    for (int ph = 0; ph < 6; ph++) begin
      for (int i = 0; i < 6; i++) begin
        if (ph == 5) c[i] = $urandom;
        else c[i] = $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
      end
      load_anchors(c[0], c[1], c[2], c[3], c[4], c[5]);
      gaps_on = (ph != 2);
      repeat (50) random_pose();
      drain();
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_backpressure;
    gaps_on = 1'b0;
    hold_request = 300;
    repeat (80) random_pose();
    gaps_on = 1'b1;
    // let every result come back, then resume
    drain();
    repeat (20) random_pose();
    drain();
  endtask

  initial begin
    anchor_x = '{default: '0};
    anchor_y = '{default: '0};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_anchors();
    test_directed();
    test_random_phases();
    test_backpressure();
    if (mismatches == 0) begin
      $display("three_anchor_planar_kinematics test passed");
    end else begin
      $display("three_anchor_planar_kinematics test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/tapk_pkg.sv
hw/rtl/tapk_iter.sv
hw/rtl/three_anchor_planar_kinematics.sv
test/three_anchor_planar_kinematics_test.sv
